// ===== hdl/lz77_hash_chain_insert_assert.svh =====
`ifndef LZ77_HASH_CHAIN_INSERT_ASSERT_SVH
`define LZ77_HASH_CHAIN_INSERT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LZHC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define LZHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lzhc_pkg.sv =====
package lzhc_pkg;

  localparam int DICT_BITS_DEF = 13;
  localparam int HASH_BITS_DEF = 10;

  // Depth of the operation queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Operation kinds carried through the queue.
  localparam logic OP_EMPTY  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hdl/lzhc_ram.sv =====
module lzhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lzhc_fifo.sv =====
module lzhc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   pop,
  output logic [WIDTH-1:0]       rdata,
  output lzhc_pkg::queue_status_t status
);

  logic [WIDTH-1:0]               mem [lzhc_pkg::QUEUE_DEPTH];
  logic [lzhc_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [lzhc_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [lzhc_pkg::QUEUE_AW:0]    count;

  assign rdata        = mem[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (lzhc_pkg::QUEUE_AW+1)'(lzhc_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lzhc_front.sv =====
module lzhc_front #(
  parameter int DICT_BITS = lzhc_pkg::DICT_BITS_DEF,
  parameter int HASH_BITS = lzhc_pkg::HASH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [7:0]                    data_byte,
  input  logic [DICT_BITS-1:0]          position,
  input  logic                          first_of_sector,
  input  logic                          last_of_sector,
  input  logic                          clearing,
  output logic                          busy,
  input  lzhc_pkg::queue_status_t       q_status,
  output logic                          q_push,
  output logic [DICT_BITS+HASH_BITS+1:0] q_wdata
);

  localparam int SHIFT = (HASH_BITS + 2) / 3;
  localparam int NSLOT = 5;
  localparam int SW    = $clog2(NSLOT);

  typedef struct packed {
    logic                 kind;
    logic                 last;
    logic [DICT_BITS-1:0] pos;
    logic [HASH_BITS-1:0] bucket;
  } op_t;

  // Byte count of the open sector, saturating at two: only 0, 1 and "two or more" matter.
  logic [1:0]           cnt;
  logic [1:0]           cnt_next;
  logic [HASH_BITS-1:0] rh;
  logic [HASH_BITS-1:0] rh_next;
  logic [DICT_BITS-1:0] p0;
  logic [DICT_BITS-1:0] p0_next;
  logic [DICT_BITS-1:0] p1;
  logic [DICT_BITS-1:0] p1_next;

  logic [NSLOT-1:0]     slot_v;
  op_t                  slot_op [NSLOT];
  logic [NSLOT-1:0]     cand_v;
  op_t                  cand_op [NSLOT];

  logic                 accept;
  logic                 close_open;
  logic [1:0]           c1;
  logic [1:0]           c2;
  logic [HASH_BITS-1:0] rh_sh;
  logic [HASH_BITS-1:0] j;
  logic [SW-1:0]        sel;

  assign accept = start && !busy;
  assign busy   = (|slot_v) || clearing;
  assign q_push = (|slot_v) && !q_status.full;
  assign q_wdata = slot_op[sel];

  assign rh_sh = rh << SHIFT;
  assign j     = rh_sh ^ HASH_BITS'(data_byte);

  // Up to five candidate operations in model order: closing the previous sector
  // (two), the chain insertion, and closing this sector (two). At most three are live.
  always_comb begin
    logic seen;
    seen       = 1'b0;
    close_open = first_of_sector && (cnt != 2'd0);
    c1         = close_open ? 2'd0 : cnt;

    cand_v[0]  = close_open;
    cand_op[0] = '{kind: lzhc_pkg::OP_EMPTY, last: 1'b0, pos: p0, bucket: '0};
    cand_v[1]  = close_open && (cnt == 2'd2);
    cand_op[1] = '{kind: lzhc_pkg::OP_EMPTY, last: 1'b0, pos: p1, bucket: '0};
    cand_v[2]  = (c1 == 2'd2);
    cand_op[2] = '{kind: lzhc_pkg::OP_INSERT, last: 1'b0, pos: p0, bucket: j};

    unique case (c1)
      2'd2: begin
        p0_next = p1;
        p1_next = position;
        rh_next = j;
        c2      = 2'd2;
      end
      2'd1: begin
        p0_next = p0;
        p1_next = position;
        rh_next = j;
        c2      = 2'd2;
      end
      default: begin
        p0_next = position;
        p1_next = p1;
        rh_next = HASH_BITS'(data_byte);
        c2      = 2'd1;
      end
    endcase

    cand_v[3]  = last_of_sector;
    cand_op[3] = '{kind: lzhc_pkg::OP_EMPTY, last: 1'b0, pos: p0_next, bucket: '0};
    cand_v[4]  = last_of_sector && (c2 == 2'd2);
    cand_op[4] = '{kind: lzhc_pkg::OP_EMPTY, last: 1'b0, pos: p1_next, bucket: '0};
    cnt_next   = last_of_sector ? 2'd0 : c2;

    // The final live operation carries the end-of-item mark.
    for (int i = NSLOT - 1; i >= 0; i--) begin
      cand_op[i].last = cand_v[i] && !seen;
      seen            = seen || cand_v[i];
    end
  end

  // Oldest live slot goes to the queue first.
  always_comb begin
    sel = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (slot_v[i]) begin
        sel = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rh     <= '0;
      p0     <= '0;
      p1     <= '0;
      slot_v <= '0;
    end else if (accept) begin
      cnt    <= cnt_next;
      rh     <= rh_next;
      p0     <= p0_next;
      p1     <= p1_next;
      slot_v <= cand_v;
    end else if (q_push) begin
      slot_v[sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_op[i] <= cand_op[i];
      end
    end
  end

endmodule

// ===== hdl/lzhc_back.sv =====
module lzhc_back #(
  parameter int DICT_BITS = lzhc_pkg::DICT_BITS_DEF,
  parameter int HASH_BITS = lzhc_pkg::HASH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lzhc_pkg::queue_status_t        q_status,
  input  logic [DICT_BITS+HASH_BITS+1:0] q_rdata,
  output logic                           q_pop,
  output logic                           clearing,
  output logic                           result_valid,
  output logic [DICT_BITS-1:0]           out_position,
  output logic                           hashed,
  output logic [HASH_BITS-1:0]           bucket,
  output logic [DICT_BITS-1:0]           older_position,
  output logic                           older_valid,
  output logic                           last_result
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  typedef struct packed {
    logic                 kind;
    logic                 last;
    logic [DICT_BITS-1:0] pos;
    logic [HASH_BITS-1:0] bucket;
  } op_t;

  op_t                  head_op;
  op_t                  cur;
  logic [1:0]           st;
  logic [HASH_BITS-1:0] clr_cnt;

  // Head table entry: valid flag above the stored position.
  logic                 we;
  logic [HASH_BITS-1:0] waddr;
  logic [DICT_BITS:0]   wdata;
  logic [DICT_BITS:0]   rdata;

  assign head_op  = op_t'(q_rdata);
  assign clearing = (st == ST_CLEAR);

  lzhc_ram #(
    .WIDTH(DICT_BITS + 1),
    .DEPTH(2 ** HASH_BITS)
  ) u_heads (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(head_op.bucket),
    .rdata(rdata)
  );

  always_comb begin
    q_pop = 1'b0;
    we    = 1'b0;
    waddr = cur.bucket;
    wdata = {1'b1, cur.pos};
    unique case (st)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      ST_IDLE: begin
        q_pop = !q_status.empty;
      end
      ST_READ: begin
        we = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (st)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            st <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            if (head_op.kind == lzhc_pkg::OP_EMPTY) begin
              result_valid <= 1'b1;
            end else begin
              st <= ST_READ;
            end
          end
        end
        ST_READ: begin
          result_valid <= 1'b1;
          st           <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // An insertion result is formed once the old head is back from the table.
  always_ff @(posedge clk) begin
    if (st == ST_IDLE && q_pop) begin
      cur            <= head_op;
      out_position   <= head_op.pos;
      hashed         <= 1'b0;
      bucket         <= '0;
      older_position <= '0;
      older_valid    <= 1'b0;
      last_result    <= head_op.last;
    end else if (st == ST_READ) begin
      out_position   <= cur.pos;
      hashed         <= 1'b1;
      bucket         <= cur.bucket;
      older_valid    <= rdata[DICT_BITS];
      older_position <= rdata[DICT_BITS] ? rdata[DICT_BITS-1:0] : '0;
      last_result    <= cur.last;
    end
  end

endmodule

// ===== hdl/lz77_hash_chain_insert.sv =====
// Sector bytes enter one per transfer with start while busy is low; results leave on
// result_valid for exactly one cycle each and cannot be held off. An item that causes no
// result leaves the input free again in the next cycle; an item causing n results (at
// most three) keeps busy high while its operations move into a four-entry queue. The
// back end handles each chain insertion as a registered head-table read, then the head
// write and result, and each empty-link result straight from the queue. The input can
// take new bytes while the back end still works on earlier ones. After reset, busy stays
// high while all 2**HASH_BITS head-table entries (1024 by default) are cleared.
module lz77_hash_chain_insert #(
  parameter int DICT_BITS = lzhc_pkg::DICT_BITS_DEF,
  parameter int HASH_BITS = lzhc_pkg::HASH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           data_byte,
  input  logic [DICT_BITS-1:0] position,
  input  logic                 first_of_sector,
  input  logic                 last_of_sector,
  output logic                 result_valid,
  output logic [DICT_BITS-1:0] out_position,
  output logic                 hashed,
  output logic [HASH_BITS-1:0] bucket,
  output logic [DICT_BITS-1:0] older_position,
  output logic                 older_valid,
  output logic                 last_result
);

  localparam int OP_W = DICT_BITS + HASH_BITS + 2;

  lzhc_pkg::queue_status_t q_status;
  logic                    q_push;
  logic                    q_pop;
  logic [OP_W-1:0]         q_wdata;
  logic [OP_W-1:0]         q_rdata;
  logic                    clearing;

  lzhc_front #(
    .DICT_BITS(DICT_BITS),
    .HASH_BITS(HASH_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .data_byte      (data_byte),
    .position       (position),
    .first_of_sector(first_of_sector),
    .last_of_sector (last_of_sector),
    .clearing       (clearing),
    .busy           (busy),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  lzhc_fifo #(
    .WIDTH(OP_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .status(q_status)
  );

  lzhc_back #(
    .DICT_BITS(DICT_BITS),
    .HASH_BITS(HASH_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .result_valid  (result_valid),
    .out_position  (out_position),
    .hashed        (hashed),
    .bucket        (bucket),
    .older_position(older_position),
    .older_valid   (older_valid),
    .last_result   (last_result)
  );

endmodule

// ===== hdl/lzhc_checker.sv =====
`include "lz77_hash_chain_insert_assert.svh"

module lzhc_checker #(
  parameter int DICT_BITS = lzhc_pkg::DICT_BITS_DEF,
  parameter int HASH_BITS = lzhc_pkg::HASH_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 last_of_sector,
  input logic                 result_valid,
  input logic                 hashed,
  input logic [HASH_BITS-1:0] bucket,
  input logic [DICT_BITS-1:0] older_position,
  input logic                 older_valid
);

  logic chain_clear;

  assign chain_clear = (bucket == '0) && (older_position == '0) && !older_valid;

  // A position given empty links reports no bucket and no older position.
  `LZHC_ASSERT_SAME(a_empty_links, result_valid && !hashed, chain_clear, "empty link with chain")

  `LZHC_ASSERT_SAME(a_older, result_valid && !older_valid, ~|older_position, "stray older link")

  // A sector end always leaves at least one position to finish, so the input must close.
  `LZHC_ASSERT_NEXT(a_last_busy, start && !busy && last_of_sector, busy, "sector end left no work")

endmodule

bind lz77_hash_chain_insert lzhc_checker #(
  .DICT_BITS(DICT_BITS),
  .HASH_BITS(HASH_BITS)
) u_checker (.*);
